FILE: src/bounded_sorted_candidate_list_assert.svh
// assertion macros for the bounded sorted candidate list
`ifndef BOUNDED_SORTED_CANDIDATE_LIST_ASSERT_SVH
`define BOUNDED_SORTED_CANDIDATE_LIST_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define BSC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent in the same cycle as the antecedent
`define BSC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bsc_pkg.sv
// shared constants, types and helpers for the bounded sorted candidate list
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

   localparam int MAX_ENTRIES   = 256;
   localparam int VERTEX_BITS   = 20;
   localparam int DIST_W        = 31;
   localparam int ACT_W         = 3;
   localparam int INDEX_W       = 8;
   localparam int LIMIT_W       = 9;
   localparam int COUNT_FIELD_W = 9;
   localparam int ERR_W         = 2;

   localparam int IDX_W     = $clog2(MAX_ENTRIES);
   localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int PAD_N     = 1 << IDX_W;
   localparam int LO_W      = 4;
   localparam int HI_W      = (IDX_W > LO_W) ? IDX_W - LO_W : 1;
   localparam int ADDR_W    = LO_W + HI_W;
   localparam int GRP_N     = 1 << LO_W;
   localparam int NGRP      = 1 << HI_W;
   localparam int CMP_W     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int LIM_CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

   localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SEED      = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CANDIDATE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_COMMIT    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_POP       = 3'd4;
   localparam logic [ACT_W-1:0] ACT_READ      = 3'd5;

   localparam logic [ERR_W-1:0] ERR_NONE          = 2'd0;
   localparam logic [ERR_W-1:0] ERR_POP_EMPTY     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_SEED_NONEMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND_SHIFT,
      ST_CAND_POS,
      ST_READ_A,
      ST_READ_B,
      ST_EXEC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [DIST_W-1:0]      dist_bits;
      logic [VERTEX_BITS-1:0] vtx;
   } entry_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic      insert;
      logic      seed;
      entry_type item;
   } cell_ctl_type;

   // what a cell hands to its right-hand neighbour
   typedef struct packed {
      logic      keep;
      entry_type item;
   } cell_link_type;

   // zero acts as one, anything above the depth acts as the depth
   function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
      logic [LIM_CMP_W-1:0] lw;
      logic [CNT_W-1:0]     res;
      lw = LIM_CMP_W'(lim);
      if (lim == '0) begin
         res = CNT_W'(1);
      end else if (lw > LIM_CMP_W'(MAX_ENTRIES)) begin
         res = CNT_W'(MAX_ENTRIES);
      end else begin
         res = CNT_W'(lw);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: src/bsc_req_if.sv
// request channel: action and candidate fields with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface bsc_req_if
   import bsc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [ACT_W-1:0]       action;
   logic [DIST_W-1:0]      distance_bits;
   logic [VERTEX_BITS-1:0] vertex_id;
   logic [INDEX_W-1:0]     entry_index;

   modport source (output valid, action, distance_bits, vertex_id, entry_index,
                   input ready);
   modport sink   (input valid, action, distance_bits, vertex_id, entry_index,
                   output ready);
endinterface

`default_nettype wire

FILE: src/bsc_rsp_if.sv
// response channel: returned entry and list status with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface bsc_rsp_if
   import bsc_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     valid_res;
   logic [DIST_W-1:0]        out_distance_bits;
   logic [VERTEX_BITS-1:0]   out_vertex_id;
   logic [ERR_W-1:0]         error_code;
   logic [COUNT_FIELD_W-1:0] list_count;
   logic                     is_empty;

   modport source (output valid, valid_res, out_distance_bits, out_vertex_id, error_code,
                   list_count, is_empty, input ready);
   modport sink   (input valid, valid_res, out_distance_bits, out_vertex_id, error_code,
                   list_count, is_empty, output ready);
endinterface

`default_nettype wire

FILE: src/bsc_cell.sv
// one slot of the sorted row: compare against the candidate, keep, load or shift
`timescale 1ns / 1ps
`default_nettype none

module bsc_cell
   import bsc_pkg::*;
(
   input  wire           clock,
   input  cell_ctl_type  ctl,
   input  wire           in_range,
   input  wire           keep,
   input  wire           seed_here,
   input  cell_link_type prev,
   output logic          le,
   output cell_link_type link
);

   entry_type entry_ff;
   entry_type entry_in;

   // slot holds a live entry not above the candidate
   assign le = in_range && (entry_ff.dist_bits <= ctl.item.dist_bits);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (!keep) begin
            entry_in = prev.keep ? ctl.item : prev.item;
         end
      end else if (ctl.seed && seed_here) begin
         entry_in = ctl.item;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link.keep = keep;
   assign link.item = entry_ff;

endmodule

`default_nettype wire

FILE: src/bsc_read_tree.sv
// two-level registered selector that reads one slot of the row by address
`timescale 1ns / 1ps
`default_nettype none

module bsc_read_tree
   import bsc_pkg::*;
(
   input  wire               clock,
   input  entry_type         slots [MAX_ENTRIES],
   input  wire  [ADDR_W-1:0] addr,
   output entry_type         rd_data
);

   entry_type             padded [NGRP][GRP_N];
   entry_type             grp_ff [NGRP];
   logic      [HI_W-1:0]  hi_ff;
   entry_type             out_ff;

   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      for (genvar j = 0; j < GRP_N; j++) begin : g_slot
         if (g * GRP_N + j < MAX_ENTRIES) begin : g_live
            assign padded[g][j] = slots[g * GRP_N + j];
         end else begin : g_pad
            assign padded[g][j] = '0;
         end
      end
   end

   // first level picks within each group, second picks the group
   always_ff @(posedge clock) begin
      for (int g = 0; g < NGRP; g++) begin
         grp_ff[g] <= padded[g][addr[LO_W-1:0]];
      end
      hi_ff  <= addr[ADDR_W-1:LO_W];
      out_ff <= grp_ff[hi_ff];
   end

   assign rd_data = out_ff;

endmodule

`default_nettype wire

FILE: src/bounded_sorted_candidate_list.sv
// top level: sorted candidate list with visit cursor, built as a row of cells
//
//  channel  direction  handshake            contents
//  req_if   in         valid/ready          action, distance, vertex, entry index
//  rsp_if   out        valid/ready          entry, error code, count, empty flag
//  csr_*    in         csr_wr_en, no ready  list limit
//
// one item at a time, from transfer in to result register:
//   clear, seed, commit and unused actions go through the execute and finish states;
//   a candidate makes one compare pass across the cell row, then the shift and the
//   position encode; pop and read first pass the two levels of the registered read tree.
// synchronous reset empties the list and sets the limit to 256; slot contents
//   are not cleared, the count guards them.
// a finished result waits only while the output register still holds one untaken.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_sorted_candidate_list_assert.svh"

module bounded_sorted_candidate_list
   import bsc_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   bsc_req_if.sink            req_if,
   bsc_rsp_if.source          rsp_if,
   input  wire                csr_wr_en,
   input  wire  [LIMIT_W-1:0] csr_wr_data
);

   state_type state_ff, state_in;

   logic [ACT_W-1:0]   op_ff;
   entry_type          item_ff;
   logic [INDEX_W-1:0] kidx_ff;
   logic [ADDR_W-1:0]  rd_addr_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   cursor_ff, cursor_in;
   logic               batch_ff, batch_in;
   logic [CNT_W-1:0]   lowest_ff, lowest_in;
   logic [LIMIT_W-1:0] limit_ff;

   logic               res_valid_ff, res_valid_in;
   logic [ERR_W-1:0]   res_err_ff, res_err_in;

   logic [MAX_ENTRIES-1:0] le_vec;
   logic [MAX_ENTRIES-1:0] le_ff;
   logic [MAX_ENTRIES-1:0] keep_vec;

   logic                     rsp_valid_ff;
   logic                     rsp_vres_ff;
   logic [DIST_W-1:0]        rsp_dist_ff;
   logic [VERTEX_BITS-1:0]   rsp_vtx_ff;
   logic [ERR_W-1:0]         rsp_err_ff;
   logic [COUNT_FIELD_W-1:0] rsp_cnt_ff;
   logic                     rsp_empty_ff;

   logic [CNT_W-1:0] lim;
   logic [CNT_W-1:0] cnt_eff;
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] commit_m1, commit_m2, commit_cur;
   logic             req_fire, rsp_fire, out_free, rsp_load;
   logic             has_unvisited, seed_ok, read_hit;

   cell_ctl_type  cell_ctl;
   cell_link_type link [MAX_ENTRIES];
   entry_type     slots [MAX_ENTRIES];
   entry_type     rd_data;

   // leading run of set flags, by doubling steps of a prefix and
   function automatic logic [MAX_ENTRIES-1:0] prefix_ones(input logic [MAX_ENTRIES-1:0] t);
      logic [MAX_ENTRIES-1:0] p;
      p = t;
      for (int s = 1; s < MAX_ENTRIES; s = s * 2) begin
         p = p & ~(~p << s);
      end
      return p;
   endfunction

   // position of the first clear flag in a thermometer, by halving steps
   function automatic logic [CNT_W-1:0] therm_pos(input logic [MAX_ENTRIES-1:0] t);
      logic [PAD_N-1:0] tp;
      logic [IDX_W-1:0] acc;
      logic [IDX_W-1:0] probe;
      logic [CNT_W-1:0] res;
      tp  = PAD_N'(t);
      acc = '0;
      for (int b = IDX_W - 1; b >= 0; b--) begin
         probe = acc | IDX_W'((1 << b) - 1);
         if (tp[probe]) begin
            acc = acc | IDX_W'(1 << b);
         end
      end
      if (t[MAX_ENTRIES-1]) begin
         res = CNT_W'(MAX_ENTRIES);
      end else begin
         res = CNT_W'(acc);
      end
      return res;
   endfunction

   assign lim           = eff_limit(limit_ff);
   assign cnt_eff       = (count_ff > lim) ? lim : count_ff;
   // an appended seed can leave the row unsorted, so a slot keeps only behind an unbroken run
   assign keep_vec      = prefix_ones(le_ff);
   assign pos           = therm_pos(keep_vec);
   assign req_fire      = req_if.valid && req_if.ready;
   assign rsp_fire      = rsp_if.valid && rsp_if.ready;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign has_unvisited = cursor_ff < count_ff;
   assign seed_ok       = !has_unvisited && (count_ff < lim);
   assign read_hit      = CMP_W'(kidx_ff) < CMP_W'(count_ff);

   assign commit_m1  = (lowest_ff < cursor_ff) ? lowest_ff : cursor_ff;
   assign commit_m2  = (lim < commit_m1) ? lim : commit_m1;
   assign commit_cur = (count_ff < commit_m2) ? count_ff : commit_m2;

   // ---------------- cell row ----------------
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic          in_range;
      logic          seed_here;
      cell_link_type prev;

      assign in_range  = CNT_W'(i) < cnt_eff;
      assign seed_here = count_ff == CNT_W'(i);

      if (i == 0) begin : g_head
         assign prev.keep = 1'b1;
         assign prev.item = item_ff;
      end else begin : g_body
         assign prev = link[i-1];
      end

      bsc_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .in_range  (in_range),
         .keep      (keep_vec[i]),
         .seed_here (seed_here),
         .prev      (prev),
         .le        (le_vec[i]),
         .link      (link[i])
      );

      assign slots[i] = link[i].item;
   end

   bsc_read_tree u_read_tree (
      .clock   (clock),
      .slots   (slots),
      .addr    (rd_addr_ff),
      .rd_data (rd_data)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.action)
                  ACT_CANDIDATE: state_in = ST_CAND_POS;
                  ACT_POP:       state_in = ST_READ_A;
                  ACT_READ:      state_in = ST_READ_A;
                  default:       state_in = ST_EXEC;
               endcase
            end
         end
         ST_CAND_POS:   state_in = ST_CAND_SHIFT;
         ST_CAND_SHIFT: state_in = ST_FINISH;
         ST_READ_A:     state_in = ST_READ_B;
         ST_READ_B:     state_in = ST_EXEC;
         ST_EXEC:       state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready    = state_ff == ST_IDLE;
      cell_ctl.insert = state_ff == ST_CAND_SHIFT;
      cell_ctl.seed   = (state_ff == ST_EXEC) && (op_ff == ACT_SEED) && seed_ok;
      cell_ctl.item   = item_ff;
      rsp_load        = (state_ff == ST_FINISH) && out_free;
   end

   // list state updates
   always_comb begin
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      batch_in     = batch_ff;
      lowest_in    = lowest_ff;
      res_valid_in = res_valid_ff;
      res_err_in   = res_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_valid_in = 1'b0;
               res_err_in   = ERR_NONE;
            end
         end
         ST_CAND_POS: begin
            // truncate to a lowered limit before the candidate lands
            count_in  = cnt_eff;
            cursor_in = (cursor_ff > cnt_eff) ? cnt_eff : cursor_ff;
            batch_in  = 1'b1;
         end
         ST_CAND_SHIFT: begin
            lowest_in = (pos < lowest_ff) ? pos : lowest_ff;
            if ((pos < lim) && (count_ff < lim)) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_EXEC: begin
            case (op_ff)
               ACT_CLEAR: begin
                  count_in  = '0;
                  cursor_in = '0;
                  batch_in  = 1'b0;
                  lowest_in = CNT_W'(MAX_ENTRIES);
               end
               ACT_SEED: begin
                  if (has_unvisited) begin
                     res_err_in = ERR_SEED_NONEMPTY;
                  end else if (seed_ok) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               ACT_COMMIT: begin
                  cursor_in = batch_ff ? commit_cur : '0;
                  batch_in  = 1'b0;
                  lowest_in = CNT_W'(MAX_ENTRIES);
               end
               ACT_POP: begin
                  if (has_unvisited) begin
                     res_valid_in = 1'b1;
                     cursor_in    = cursor_ff + CNT_W'(1);
                  end else begin
                     res_err_in = ERR_POP_EMPTY;
                  end
               end
               ACT_READ: begin
                  res_valid_in = read_hit;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         batch_ff     <= 1'b0;
         lowest_ff    <= CNT_W'(MAX_ENTRIES);
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         batch_ff  <= batch_in;
         lowest_ff <= lowest_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_valid_ff <= res_valid_in;
      res_err_ff   <= res_err_in;
      if (req_fire) begin
         op_ff             <= req_if.action;
         item_ff.dist_bits <= req_if.distance_bits;
         item_ff.vtx       <= req_if.vertex_id;
         kidx_ff           <= req_if.entry_index;
         rd_addr_ff        <= (req_if.action == ACT_POP) ? ADDR_W'(cursor_ff)
                                                         : ADDR_W'(req_if.entry_index);
      end
      if (state_ff == ST_CAND_POS) begin
         le_ff <= le_vec;
      end
      if (rsp_load) begin
         rsp_vres_ff  <= res_valid_ff;
         rsp_dist_ff  <= res_valid_ff ? rd_data.dist_bits : '0;
         rsp_vtx_ff   <= res_valid_ff ? rd_data.vtx : '0;
         rsp_err_ff   <= res_err_ff;
         rsp_cnt_ff   <= COUNT_FIELD_W'(count_ff);
         rsp_empty_ff <= cursor_ff >= count_ff;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.valid_res         = rsp_vres_ff;
   assign rsp_if.out_distance_bits = rsp_dist_ff;
   assign rsp_if.out_vertex_id     = rsp_vtx_ff;
   assign rsp_if.error_code        = rsp_err_ff;
   assign rsp_if.list_count        = rsp_cnt_ff;
   assign rsp_if.is_empty          = rsp_empty_ff;

   // ---------------- checks ----------------
   `BSC_ASSERT_ALWAYS(a_cursor_in_list, (cursor_ff <= count_ff) && (count_ff <= CNT_W'(MAX_ENTRIES)), "cursor or count out of range")
   `BSC_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_ff != ST_IDLE, "transfer accepted but sequencer stayed idle")
   `BSC_ASSERT_IMPLIES(a_row_keep_prefix, state_ff == ST_CAND_SHIFT, (keep_vec & (keep_vec + MAX_ENTRIES'(1))) == '0, "keep flags of the row are not a prefix")
   `BSC_ASSERT_NEXT(a_cand_grows_by_one, state_ff == ST_CAND_SHIFT, count_ff <= $past(count_ff) + CNT_W'(1), "candidate added more than one entry")

endmodule

`default_nettype wire

FILE: sim/bounded_sorted_candidate_list_test.sv
// self-checking testbench for the bounded sorted candidate list
`timescale 1ns / 1ps

module bounded_sorted_candidate_list_test;
   import bsc_pkg::*;

   localparam int unsigned RESET_CYCLES  = 8;
   localparam int unsigned MAX_IDLE      = 12;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned CYCLE_LIMIT   = 250000;

   localparam logic [ACT_W-1:0]       ACT_SPARE_LO = 3'd6;
   localparam logic [ACT_W-1:0]       ACT_SPARE_HI = 3'd7;
   localparam logic [DIST_W-1:0]      MAX_DIST     = 31'h7F7F_FFFF;
   localparam logic [DIST_W-1:0]      ONE_DIST     = 31'h3F80_0000;
   localparam logic [VERTEX_BITS-1:0] MAX_VERTEX   = '1;

   // limit per random phase, with the out-of-range settings among them
   localparam logic [LIMIT_W-1:0] PHASE_LIMITS [10] =
      '{9'd256, 9'd16, 9'd1, 9'd0, 9'd3, 9'd511, 9'd100, 9'd2, 9'd257, 9'd40};
   localparam int unsigned PHASE_ITEMS [10] =
      '{260, 90, 60, 50, 70, 120, 90, 50, 80, 60};

   typedef struct packed {
      logic                     entry_valid;
      logic [DIST_W-1:0]        distance;
      logic [VERTEX_BITS-1:0]   vertex;
      logic [ERR_W-1:0]         error_code;
      logic [COUNT_FIELD_W-1:0] count;
      logic                     empty;
   } list_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   bsc_req_if req_if ();
   bsc_rsp_if rsp_if ();

   bounded_sorted_candidate_list u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // predicted list contents and control state
   logic [DIST_W-1:0]      model_dist [MAX_ENTRIES];
   logic [VERTEX_BITS-1:0] model_vtx  [MAX_ENTRIES];
   int unsigned            model_count;
   int unsigned            model_cursor;
   int unsigned            model_lowest;
   bit                     model_batch_open;
   logic [LIMIT_W-1:0]     model_limit;

   list_reply_type pending_replies [$];
   list_reply_type oldest_reply;

   bit          request_offered;
   bit          sender_gaps_on;
   bit          receiver_stalls_on;
   int unsigned hold_request;

   int unsigned cycles_run;
   int unsigned items_sent;
   int unsigned results_checked;
   int unsigned mismatches;
   int unsigned limit_writes;
   int unsigned deepest_list;
   int unsigned entries_popped;
   int unsigned empty_pops;
   int unsigned seeds_refused;

   function automatic int unsigned effective_limit();
      int unsigned lim;
      lim = 32'(model_limit);
      if (lim == 0) lim = 1;
      if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
      return lim;
   endfunction

   function automatic list_reply_type predict_list_step(input logic [ACT_W-1:0]       act,
                                                        input logic [DIST_W-1:0]      dist_bits,
                                                        input logic [VERTEX_BITS-1:0] vtx,
                                                        input logic [INDEX_W-1:0]     idx);
      list_reply_type reply;
      int unsigned lim;
      int unsigned pos;
      int unsigned i;
      reply = '0;
      lim   = effective_limit();
      case (act)
         ACT_CLEAR: begin
            model_count      = 0;
            model_cursor     = 0;
            model_batch_open = 1'b0;
            model_lowest     = MAX_ENTRIES;
         end
         ACT_SEED: begin
            if (model_cursor < model_count) begin
               reply.error_code = ERR_SEED_NONEMPTY;
               seeds_refused++;
            end else if (model_count < lim) begin
               model_dist[model_count] = dist_bits;
               model_vtx[model_count]  = vtx;
               model_count++;
            end
         end
         ACT_CANDIDATE: begin
            // a lowered limit only takes effect on the next candidate
            if (model_count > lim) model_count = lim;
            if (model_cursor > model_count) model_cursor = model_count;
            pos = 0;
            while (pos < model_count && model_dist[pos] <= dist_bits) pos++;
            model_batch_open = 1'b1;
            if (pos < model_lowest) model_lowest = pos;
            if (pos < lim) begin
               i = (model_count < lim) ? model_count : lim - 1;
               while (i > pos) begin
                  model_dist[i] = model_dist[i-1];
                  model_vtx[i]  = model_vtx[i-1];
                  i--;
               end
               model_dist[pos] = dist_bits;
               model_vtx[pos]  = vtx;
               if (model_count < lim) model_count++;
            end
         end
         ACT_COMMIT: begin
            if (model_batch_open) begin
               if (model_lowest < model_cursor) model_cursor = model_lowest;
               if (lim < model_cursor) model_cursor = lim;
               if (model_count < model_cursor) model_cursor = model_count;
            end else begin
               model_cursor = 0;
            end
            model_batch_open = 1'b0;
            model_lowest     = MAX_ENTRIES;
         end
         ACT_POP: begin
            if (model_cursor < model_count) begin
               reply.entry_valid = 1'b1;
               reply.distance    = model_dist[model_cursor];
               reply.vertex      = model_vtx[model_cursor];
               model_cursor++;
               entries_popped++;
            end else begin
               reply.error_code = ERR_POP_EMPTY;
               empty_pops++;
            end
         end
         ACT_READ: begin
            if (idx < model_count) begin
               reply.entry_valid = 1'b1;
               reply.distance    = model_dist[idx];
               reply.vertex      = model_vtx[idx];
            end
         end
         default: ;
      endcase
      reply.count = COUNT_FIELD_W'(model_count);
      reply.empty = (model_cursor >= model_count);
      if (model_count > deepest_list) deepest_list = model_count;
      return reply;
   endfunction

   // mostly spread over the whole range, with a small pool of values to force ties
   function automatic logic [DIST_W-1:0] pick_distance();
      logic [DIST_W-1:0] dist_bits;
      case ($urandom_range(0, 5))
         0: dist_bits = $urandom_range(0, 1) ? MAX_DIST : '0;
         1, 2: dist_bits = DIST_W'($urandom_range(0, 7)) << 23;
         default: dist_bits = DIST_W'($urandom_range(0, MAX_DIST));
      endcase
      return dist_bits;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s at result %0d: got %0h, want %0h",
               what, results_checked, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic send_list_action(input logic [ACT_W-1:0]       act,
                                   input logic [DIST_W-1:0]      dist_bits,
                                   input logic [VERTEX_BITS-1:0] vtx,
                                   input logic [INDEX_W-1:0]     idx);
      int unsigned    gap;
      list_reply_type predicted;
      gap = sender_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         if (request_offered) begin
            req_if.valid <= 1'b0;
            request_offered = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      // with no gap, valid stays high and only the payload moves on
      req_if.valid         <= 1'b1;
      req_if.action        <= act;
      req_if.distance_bits <= dist_bits;
      req_if.vertex_id     <= vtx;
      req_if.entry_index   <= idx;
      request_offered = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predicted       = predict_list_step(act, dist_bits, vtx, idx);
      pending_replies = {pending_replies, predicted};
      items_sent++;
   endtask

   task automatic park_request();
      if (request_offered) begin
         req_if.valid <= 1'b0;
         request_offered = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_replies();
      park_request();
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_list_limit(input logic [LIMIT_W-1:0] value);
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_limit = value;
      limit_writes++;
      @(posedge clock);
   endtask

   // pop, expand into a batch of candidates, commit; seed when nothing is left; with some noise mixed in
   task automatic run_search_traffic(input int unsigned n_items);
      int unsigned first_item;
      int unsigned batch;
      first_item = items_sent;
      while (items_sent - first_item < n_items) begin
         if ($urandom_range(0, 99) < 12) begin
            send_list_action(ACT_W'($urandom_range(ACT_CLEAR, ACT_SPARE_HI)),
                             DIST_W'($urandom_range(0, MAX_DIST)),
                             VERTEX_BITS'($urandom), INDEX_W'($urandom));
         end else if (model_cursor >= model_count || $urandom_range(0, 24) == 0) begin
            if ($urandom_range(0, 3) != 0)
               send_list_action(ACT_CLEAR, pick_distance(), VERTEX_BITS'($urandom),
                                INDEX_W'($urandom));
            send_list_action(ACT_SEED, pick_distance(), VERTEX_BITS'($urandom),
                             INDEX_W'($urandom));
         end else begin
            send_list_action(ACT_POP, pick_distance(), VERTEX_BITS'($urandom),
                             INDEX_W'($urandom));
            batch = $urandom_range(0, 10);
            repeat (batch)
               send_list_action(ACT_CANDIDATE, pick_distance(), VERTEX_BITS'($urandom),
                                INDEX_W'($urandom));
            send_list_action(ACT_COMMIT, pick_distance(), VERTEX_BITS'($urandom),
                             INDEX_W'($urandom));
            if ($urandom_range(0, 3) == 0)
               send_list_action(ACT_READ, pick_distance(), VERTEX_BITS'($urandom),
                                (model_count > 0) ? INDEX_W'($urandom_range(0, model_count - 1))
                                                  : INDEX_W'($urandom));
         end
      end
   endtask

   task automatic test_directed_actions();
      send_list_action(ACT_POP, '0, '0, '0);                 // nothing to pop
      send_list_action(ACT_READ, MAX_DIST, MAX_VERTEX, '1);  // index past the count
      send_list_action(ACT_COMMIT, '0, '0, '0);              // no batch open
      send_list_action(ACT_SEED, ONE_DIST, MAX_VERTEX, '0);
      send_list_action(ACT_SEED, ONE_DIST, 20'd5, '0);       // refused, list not empty
      send_list_action(ACT_CANDIDATE, '0, '0, '1);
      send_list_action(ACT_CANDIDATE, MAX_DIST, 20'd1, '0);
      send_list_action(ACT_CANDIDATE, ONE_DIST, 20'd2, '0);  // tie lands after the seed
      send_list_action(ACT_COMMIT, '0, '0, '0);
      send_list_action(ACT_READ, '0, '0, 8'd2);
      repeat (5) send_list_action(ACT_POP, '0, '0, '0);
      // every entry visited, so a seed is appended at the tail
      send_list_action(ACT_SEED, 31'h4000_0000, 20'hABCDE, '0);
      send_list_action(ACT_SPARE_LO, MAX_DIST, MAX_VERTEX, '1);
      send_list_action(ACT_SPARE_HI, '0, '0, '0);
      send_list_action(ACT_CANDIDATE, ONE_DIST, 20'd7, '0);
      send_list_action(ACT_CLEAR, '0, '0, '0);              // drops the open batch too
      send_list_action(ACT_COMMIT, '0, '0, '0);
   endtask

   task automatic test_limit_corners();
      write_list_limit(9'd1);
      send_list_action(ACT_SEED, 31'd7, 20'd8, '0);
      send_list_action(ACT_POP, '0, '0, '0);
      send_list_action(ACT_SEED, 31'd3, 20'd9, '0);         // list full, quietly ignored
      send_list_action(ACT_CANDIDATE, MAX_DIST, 20'd10, '0); // falls past the limit
      send_list_action(ACT_COMMIT, '0, '0, '0);
      write_list_limit(9'd0);
      send_list_action(ACT_CANDIDATE, '0, 20'd11, '0);
      write_list_limit('1);
      send_list_action(ACT_CANDIDATE, 31'd20, 20'd12, '0);
      send_list_action(ACT_CANDIDATE, 31'd10, 20'd13, '0);
      send_list_action(ACT_CANDIDATE, 31'd30, 20'd14, '0);
      write_list_limit(9'd2);
      send_list_action(ACT_READ, '0, '0, 8'd3);             // still held above the limit
      send_list_action(ACT_CANDIDATE, 31'd15, 20'd15, '0);  // truncates first
      send_list_action(ACT_COMMIT, '0, '0, '0);
   endtask

   task automatic test_backpressure();
      write_list_limit(9'd64);
      sender_gaps_on = 1'b0;
      hold_request   = HOLD_CYCLES;
      run_search_traffic(48);
      drain_replies();
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_random_search();
      foreach (PHASE_LIMITS[p]) begin
         write_list_limit(PHASE_LIMITS[p]);
         sender_gaps_on     = ($urandom_range(0, 3) != 0);
         receiver_stalls_on = ($urandom_range(0, 3) != 0);
         run_search_traffic(PHASE_ITEMS[p]);
      end
   endtask

   // result side: random stalls, or one long hold when asked for
   initial begin
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request > 0)
            stall = hold_request;
         else
            stall = receiver_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
         hold_request = 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid && hold_request == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_checked++;
         if (pending_replies.size() == 0) begin
            report_mismatch("transfer with nothing pending", '0, '0);
         end else begin
            oldest_reply = pending_replies.pop_front();
            check_field("valid_res", 32'(rsp_if.valid_res), 32'(oldest_reply.entry_valid));
            check_field("out_distance_bits", 32'(rsp_if.out_distance_bits),
                        32'(oldest_reply.distance));
            check_field("out_vertex_id", 32'(rsp_if.out_vertex_id), 32'(oldest_reply.vertex));
            check_field("error_code", 32'(rsp_if.error_code), 32'(oldest_reply.error_code));
            check_field("list_count", 32'(rsp_if.list_count), 32'(oldest_reply.count));
            check_field("is_empty", 32'(rsp_if.is_empty), 32'(oldest_reply.empty));
         end
      end
   end

   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("timed out after %0d cycles with %0d results outstanding",
               cycles_run, pending_replies.size());
      $display("FAIL");
      $finish;
   end

   initial begin
      req_if.valid         <= 1'b0;
      req_if.action        <= ACT_CLEAR;
      req_if.distance_bits <= '0;
      req_if.vertex_id     <= '0;
      req_if.entry_index   <= '0;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      model_count        = 0;
      model_cursor       = 0;
      model_batch_open   = 1'b0;
      model_lowest       = MAX_ENTRIES;
      model_limit        = LIMIT_RESET;
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_actions();
      test_limit_corners();
      test_backpressure();
      test_random_search();

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d results over %0d limit settings, deepest list %0d",
               items_sent, results_checked, limit_writes, deepest_list);
      $display("%0d entries popped, %0d pops on an exhausted list, %0d seeds refused",
               entries_popped, empty_pops, seeds_refused);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
